// ===== rtl/core/mdsmc_pkg.sv =====
package mdsmc_pkg;

    localparam int unsigned COMMAND_LENGTH = 2;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_RX      = 2'd1;
    localparam logic [1:0] OP_TX_DONE = 2'd2;

    localparam logic [1:0] PH_ADDR  = 2'd0;
    localparam logic [1:0] PH_DELAY = 2'd1;
    localparam logic [1:0] PH_SEND  = 2'd2;
    localparam logic [1:0] PH_DATA  = 2'd3;

    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_STOP       = 3'd1;
    localparam logic [2:0] CMD_RUN_LOW    = 3'd2;
    localparam logic [2:0] CMD_START_HIGH = 3'd3;
    localparam logic [2:0] CMD_SET_HIGH   = 3'd4;

    localparam logic [1:0] MOTOR_STOPPED = 2'd0;
    localparam logic [1:0] MOTOR_LOW     = 2'd1;

    localparam logic [3:0] SPEED_STOP = 4'd0;
    localparam logic [3:0] SPEED_LOW  = 4'd1;

    localparam logic [1:0] REG_STATION_ADDRESS = 2'd0;
    localparam logic [1:0] REG_ADDRESS_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_REPLY_DELAY     = 2'd2;
    localparam logic [1:0] REG_DATA_GAP        = 2'd3;

    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned CFG_DATA_WIDTH  = 16;

    localparam logic [1:0]  RESET_STATION_ADDRESS = 2'd0;
    localparam logic [15:0] RESET_ADDRESS_TIMEOUT = 16'd20;
    localparam logic [7:0]  RESET_REPLY_DELAY     = 8'd1;
    localparam logic [7:0]  RESET_DATA_GAP        = 8'd4;

    localparam logic [15:0] IDLE_TICKS_MAX = 16'hffff;
    localparam logic [7:0]  WAIT_TICKS_MAX = 8'hff;

    typedef struct packed {
        logic [1:0]  station_address;
        logic [15:0] address_timeout_ticks;
        logic [7:0]  reply_delay_ticks;
        logic [7:0]  data_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic       rx_address_bit;
        logic [1:0] sensor_bits;
        logic [3:0] voltage_index;
        logic [1:0] motor_status;
        logic       testing_mode;
    } item_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] idle_ticks;
        logic [7:0]  wait_ticks;
        logic        first_byte_seen;
        logic [7:0]  command_byte0;
        logic [4:0]  remembered_speed;
        logic [7:0]  reply_latch;
    } state_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] motor_command;
        logic       direction;
        logic [3:0] speed_code;
    } result_t;

endpackage

// ===== rtl/core/mdsmc_step.sv =====
module mdsmc_step
(
    input  mdsmc_pkg::cfg_t    cfg,
    input  mdsmc_pkg::item_t   item,
    input  mdsmc_pkg::state_t  cur,
    output mdsmc_pkg::state_t  nxt,
    output mdsmc_pkg::result_t res
);
    import mdsmc_pkg::*;

    logic [15:0] idle_inc;
    logic [7:0]  wait_inc;
    logic [4:0]  speed;
    logic        command_ok;

    assign speed = cur.command_byte0[4:0];

    assign command_ok = (cur.command_byte0 == item.rx_byte)
                     && (cur.command_byte0[7:6] == cfg.station_address)
                     && (speed != cur.remembered_speed);

    always_comb
    begin
        idle_inc = cur.idle_ticks;
        wait_inc = cur.wait_ticks;
        if (item.op == OP_TICK)
        begin
            if (cur.idle_ticks != IDLE_TICKS_MAX)
            begin
                idle_inc = cur.idle_ticks + 16'd1;
            end
            if (cur.wait_ticks != WAIT_TICKS_MAX)
            begin
                wait_inc = cur.wait_ticks + 8'd1;
            end
        end
    end

    always_comb
    begin
        nxt            = cur;
        nxt.idle_ticks = idle_inc;
        nxt.wait_ticks = wait_inc;
        res            = '0;

        unique case (cur.phase)
            PH_ADDR:
            begin
                if (item.op == OP_TICK)
                begin
                    if (idle_inc > cfg.address_timeout_ticks)
                    begin
                        nxt.idle_ticks       = '0;
                        nxt.remembered_speed = '0;
                        if (!item.testing_mode)
                        begin
                            res.motor_command = CMD_STOP;
                        end
                    end
                end
                else if (item.op == OP_RX)
                begin
                    if (item.rx_address_bit && (item.rx_byte == {6'd0, cfg.station_address}))
                    begin
                        nxt.reply_latch = {cfg.station_address, item.voltage_index,
                                           item.sensor_bits};
                        nxt.wait_ticks  = '0;
                        nxt.idle_ticks  = '0;
                        nxt.phase       = PH_DELAY;
                    end
                end
            end
            PH_DELAY:
            begin
                if ((item.op == OP_TICK) && (wait_inc > cfg.reply_delay_ticks))
                begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = cur.reply_latch;
                    nxt.phase    = PH_SEND;
                end
            end
            PH_SEND:
            begin
                if (item.op == OP_TX_DONE)
                begin
                    nxt.wait_ticks      = '0;
                    nxt.first_byte_seen = 1'b0;
                    nxt.phase           = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (item.op == OP_TICK)
                begin
                    if (wait_inc > cfg.data_gap_ticks)
                    begin
                        nxt.idle_ticks = '0;
                        nxt.phase      = PH_ADDR;
                    end
                end
                else if (item.op == OP_RX)
                begin
                    nxt.wait_ticks = '0;
                    if (!cur.first_byte_seen)
                    begin
                        nxt.command_byte0   = item.rx_byte;
                        nxt.first_byte_seen = 1'b1;
                    end
                    else
                    begin
                        // second byte completes the command
                        nxt.first_byte_seen = 1'b0;
                        nxt.idle_ticks      = '0;
                        nxt.phase           = PH_ADDR;
                        if (!item.testing_mode && command_ok)
                        begin
                            nxt.remembered_speed = speed;
                            res.direction        = speed[4];
                            res.speed_code       = speed[3:0];
                            if (speed[3:0] == SPEED_STOP)
                            begin
                                res.motor_command = CMD_STOP;
                            end
                            else if (speed[3:0] == SPEED_LOW)
                            begin
                                res.motor_command = CMD_RUN_LOW;
                            end
                            else if ((item.motor_status == MOTOR_STOPPED)
                                  || (item.motor_status == MOTOR_LOW))
                            begin
                                res.motor_command = CMD_START_HIGH;
                            end
                            else
                            begin
                                res.motor_command = CMD_SET_HIGH;
                            end
                        end
                    end
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/mdsmc_skid.sv =====
module mdsmc_skid
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mdsmc_pkg::result_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output mdsmc_pkg::result_t  out_word
);
    import mdsmc_pkg::*;

    result_t out_word_reg;
    result_t skid_word_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : in_word;
        end
        else if (accept)
        begin
            skid_word_reg <= in_word;
        end
    end

endmodule

// ===== rtl/core/multidrop_slave_motor_command.sv =====
// channel  | handshake            | words
// ---------+----------------------+----------------------------------------------
// input    | in_valid / in_stall  | op, rx_byte, rx_address_bit, sensor_bits,
//          |                      | voltage_index, motor_status, testing_mode
// output   | out_valid / out_stall| tx_valid, tx_byte, motor_command, direction,
//          |                      | speed_code
// config   | cfg_we               | cfg_index, cfg_data
//
// one word in per cycle while in_stall is low; link state is updated at the
// accepting edge, the result goes into a two-deep output register (output word
// plus skid word), into the skid word while out_stall holds the output word.
// in_stall rises only once both output slots hold untaken words.
// rst_n clears the link phase, tick counters, remembered speed and config to defaults.
module multidrop_slave_motor_command
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [mdsmc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [mdsmc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              op,
    input  logic [7:0]                              rx_byte,
    input  logic                                    rx_address_bit,
    input  logic [1:0]                              sensor_bits,
    input  logic [3:0]                              voltage_index,
    input  logic [1:0]                              motor_status,
    input  logic                                    testing_mode,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    tx_valid,
    output logic [7:0]                              tx_byte,
    output logic [2:0]                              motor_command,
    output logic                                    direction,
    output logic [3:0]                              speed_code
);
    import mdsmc_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item;
    result_t step_res;
    result_t out_word;
    logic    accept;

    assign item = '{op: op, rx_byte: rx_byte, rx_address_bit: rx_address_bit,
                    sensor_bits: sensor_bits, voltage_index: voltage_index,
                    motor_status: motor_status, testing_mode: testing_mode};

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.station_address       <= RESET_STATION_ADDRESS;
            cfg_reg.address_timeout_ticks <= RESET_ADDRESS_TIMEOUT;
            cfg_reg.reply_delay_ticks     <= RESET_REPLY_DELAY;
            cfg_reg.data_gap_ticks        <= RESET_DATA_GAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STATION_ADDRESS: cfg_reg.station_address       <= cfg_data[1:0];
                REG_ADDRESS_TIMEOUT: cfg_reg.address_timeout_ticks <= cfg_data;
                REG_REPLY_DELAY:     cfg_reg.reply_delay_ticks     <= cfg_data[7:0];
                REG_DATA_GAP:        cfg_reg.data_gap_ticks        <= cfg_data[7:0];
            endcase
        end
    end

    mdsmc_step u_step
    (
        .cfg  (cfg_reg),
        .item (item),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase            <= PH_ADDR;
            state_reg.idle_ticks       <= '0;
            state_reg.wait_ticks       <= '0;
            state_reg.first_byte_seen  <= 1'b0;
            state_reg.command_byte0    <= '0;
            state_reg.remembered_speed <= '0;
            state_reg.reply_latch      <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    mdsmc_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (step_res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign tx_valid      = out_word.tx_valid;
    assign tx_byte       = out_word.tx_byte;
    assign motor_command = out_word.motor_command;
    assign direction     = out_word.direction;
    assign speed_code    = out_word.speed_code;

    a_reply_enters_send: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step_res.tx_valid) |=> (state_reg.phase == PH_SEND))
        else $error("reply sent without entering send phase");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled while output register empty");

    a_idle_command_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (motor_command == CMD_NONE)) |-> ((direction == 1'b0)
            && (speed_code == 4'd0)))
        else $error("direction or speed set without a motor command");

    a_data_phase_from_send: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(accept) && (state_reg.phase == PH_DATA) && ($past(state_reg.phase) != PH_DATA))
            |-> ($past(state_reg.phase) == PH_SEND))
        else $error("data phase entered other than from send phase");

endmodule
